[src/pva_pkg.sv]
// pva_pkg: types and constants of the polyphonic voice allocator.
// Request and result words, event op codes, command codes, back-end states.
// No dependencies.
`default_nettype none

package pva_pkg;

	localparam int PVA_VOICES = 8;

	typedef enum logic [1:0] {
		OP_ON     = 2'd0,
		OP_OFF    = 2'd1,
		OP_ALLOFF = 2'd2,
		OP_FIN    = 2'd3
	} pva_op_t;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_RETRIG  = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_MUTE    = 2'd3
	} pva_cmd_code_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} pva_bk_state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [6:0] key;
		logic [6:0] velocity;
		logic       source;
		logic [2:0] finished_voice;
	} pva_req_t;

	typedef struct packed {
		pva_cmd_code_t command;
		logic [2:0]    voice;
		logic [6:0]    note_key;
		logic [6:0]    note_velocity;
		logic          last;
	} pva_res_t;

	// classified event between front and back
	typedef struct packed {
		pva_op_t    op;
		logic [6:0] key;
		logic [6:0] velocity;
		logic       source;
		logic [2:0] fin;
	} pva_ev_t;

endpackage

`default_nettype wire

[src/pva_fifo.sv]
// pva_fifo: two-entry word queue with full and empty flags.
// Generic storage; uses no package.
`default_nettype none

module pva_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

endmodule

`default_nettype wire

[src/pva_front.sv]
// pva_front: accepts request words, decodes the event kind, drops
// out-of-range voice-finished events, queues the rest. Uses pva_pkg, pva_fifo.
`default_nettype none

module pva_front #(
	parameter int VOICES = pva_pkg::PVA_VOICES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pva_pkg::pva_req_t req,
	output logic                   full,
	output logic                   ev_vld,
	output pva_pkg::pva_ev_t       ev,
	input  wire logic              ev_pop
);
	import pva_pkg::*;

	pva_ev_t ev_d;
	logic    keep;
	logic    q_empty;

	always_comb begin
		ev_d.key      = req.key;
		ev_d.velocity = req.velocity;
		ev_d.source   = req.source;
		ev_d.fin      = req.finished_voice;
		keep          = 1'b1;
		unique case (req.func)
			OP_ON:     ev_d.op = OP_ON;
			OP_OFF:    ev_d.op = OP_OFF;
			OP_ALLOFF: ev_d.op = OP_ALLOFF;
			default: begin
				ev_d.op = OP_FIN;
				keep    = 32'(req.finished_voice) < VOICES;
			end
		endcase
	end

	pva_fifo #(.W($bits(pva_ev_t))) u_evq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && keep),
		.wdata (ev_d),
		.full  (full),
		.pop   (ev_pop),
		.empty (q_empty),
		.rdata (ev)
	);

	assign ev_vld = !q_empty;

endmodule

`default_nettype wire

[src/pva_back.sv]
// pva_back: voice table, scan sequencer. Uses pva_pkg. Walks the voices one
// per cycle unless result queue full; emits start/retrigger/release/mute.
`default_nettype none

module pva_back #(
	parameter int VOICES = pva_pkg::PVA_VOICES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ev_vld,
	input  wire pva_pkg::pva_ev_t ev,
	output logic                  ev_pop,
	output logic                  out_push,
	output pva_pkg::pva_res_t     out_word,
	input  wire logic             out_full
);
	import pva_pkg::*;

	localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICES - 1);

	pva_bk_state_t     state_q, state_d;
	pva_ev_t           ev_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [VOICES-1:0] active_q;
	logic [7:0]        mem [VOICES];
	logic [7:0]        rd_q;
	pva_res_t          hold_q, hold_d;
	logic              hold_vld_q;
	logic              idle_fnd_q;
	logic [IDX_W-1:0]  idle_idx_q;

	logic              cur_act;
	logic              src_hit;
	logic              key_hit;
	logic              scan_last;
	logic              load;
	logic              step;
	logic              fin_clr;
	logic              hold_set;
	logic              idle_set;
	logic              on_start;

	assign cur_act   = active_q[idx_q];
	assign src_hit   = cur_act && (rd_q[0] == ev_q.source);
	assign key_hit   = src_hit && (rd_q[7:1] == ev_q.key);
	assign scan_last = idx_q == IDX_LAST;

	always_comb begin
		state_d  = state_q;
		ev_pop   = 1'b0;
		load     = 1'b0;
		step     = 1'b0;
		fin_clr  = 1'b0;
		hold_set = 1'b0;
		hold_d   = hold_q;
		idle_set = 1'b0;
		on_start = 1'b0;
		out_push = 1'b0;
		out_word = hold_q;
		unique case (state_q)
			BK_IDLE: begin
				if (ev_vld) begin
					ev_pop = 1'b1;
					if (ev.op == OP_FIN) begin
						fin_clr = 1'b1;
					end else begin
						load    = 1'b1;
						state_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				if (ev_q.op == OP_ON) begin
					step     = 1'b1;
					idle_set = !cur_act && !idle_fnd_q;
					if (key_hit && !hold_vld_q) begin
						hold_set = 1'b1;
						hold_d   = '{command: CMD_RETRIG, voice: 3'(idx_q),
							note_key: ev_q.key, note_velocity: ev_q.velocity, last: 1'b1};
					end
				end else if ((ev_q.op == OP_OFF) ? key_hit : src_hit) begin
					if (!hold_vld_q || !out_full) begin
						step     = 1'b1;
						hold_set = 1'b1;
						hold_d   = '{command: (ev_q.op == OP_OFF) ? CMD_RELEASE : CMD_MUTE,
							voice: 3'(idx_q), note_key: rd_q[7:1], note_velocity: 7'd0,
							last: 1'b0};
						if (hold_vld_q) begin
							out_push      = 1'b1;
							out_word.last = 1'b0;
						end
					end
				end else begin
					step = 1'b1;
				end
				if (step && scan_last)
					state_d = BK_FLUSH;
			end
			BK_FLUSH: begin
				if (hold_vld_q) begin
					if (!out_full) begin
						out_push      = 1'b1;
						out_word.last = 1'b1;
						state_d       = BK_IDLE;
					end
				end else if (ev_q.op == OP_ON && idle_fnd_q) begin
					if (!out_full) begin
						out_push = 1'b1;
						on_start = 1'b1;
						out_word = '{command: CMD_START, voice: 3'(idle_idx_q),
							note_key: ev_q.key, note_velocity: ev_q.velocity, last: 1'b1};
						state_d  = BK_IDLE;
					end
				end else begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == BK_SCAN && !(step && scan_last))
			rd_addr = step ? idx_q + 1'b1 : idx_q;
		else
			rd_addr = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			idx_q      <= '0;
			active_q   <= '0;
			hold_vld_q <= 1'b0;
			idle_fnd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				idx_q      <= '0;
				hold_vld_q <= 1'b0;
				idle_fnd_q <= 1'b0;
			end else begin
				if (step && !scan_last)
					idx_q <= idx_q + 1'b1;
				if (hold_set)
					hold_vld_q <= 1'b1;
				if (idle_set)
					idle_fnd_q <= 1'b1;
			end
			if (fin_clr)
				active_q[IDX_W'(ev.fin)] <= 1'b0;
			if (on_start)
				active_q[idle_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			ev_q <= ev;
		if (hold_set)
			hold_q <= hold_d;
		if (idle_set)
			idle_idx_q <= idx_q;
		if (on_start)
			mem[idle_idx_q] <= {ev_q.key, ev_q.source};
		rd_q <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[src/polyphonic_voice_allocator.sv]
// polyphonic_voice_allocator: top level. Front decoder and event queue,
// back voice scanner, result queue. Uses pva_pkg, pva_front, pva_back, pva_fifo.
//
//   channel   handshake          word
//   request   push / full        req (pva_req_t)
//   result    pop / empty        cmd (pva_res_t)
//
// Note on, note off, all off: the back scanner walks one voice per cycle,
// stalling on a full result queue. Voice finished: cleared in idle, no scan.
// The front takes a word per cycle while its two-entry queue has room.
// Reset clears all voices to idle; no clearing pass.
`default_nettype none

module polyphonic_voice_allocator #(
	parameter int VOICES = pva_pkg::PVA_VOICES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire pva_pkg::pva_req_t req,
	output logic                   empty,
	input  wire logic              pop,
	output pva_pkg::pva_res_t      cmd
);
	import pva_pkg::*;

	logic     ev_vld;
	pva_ev_t  ev;
	logic     ev_pop;
	logic     bk_push;
	pva_res_t bk_word;
	logic     out_full;

	pva_front #(.VOICES(VOICES)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.req   (req),
		.full  (full),
		.ev_vld(ev_vld),
		.ev    (ev),
		.ev_pop(ev_pop)
	);

	pva_back #(.VOICES(VOICES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ev_vld  (ev_vld),
		.ev      (ev),
		.ev_pop  (ev_pop),
		.out_push(bk_push),
		.out_word(bk_word),
		.out_full(out_full)
	);

	pva_fifo #(.W($bits(pva_res_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (bk_push),
		.wdata (bk_word),
		.full  (out_full),
		.pop   (pop),
		.empty (empty),
		.rdata (cmd)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		bk_push |-> !out_full)
		else $error("result word pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ev_pop |-> ev_vld)
		else $error("event popped from empty queue");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (cmd.command == CMD_START || cmd.command == CMD_RETRIG)) |-> cmd.last)
		else $error("start or retrigger without last mark");

endmodule

`default_nettype wire
